[sv/assert_macros.svh]
// Assertion macros for the RTL files; circle_center_from_three_points includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define CCF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CCF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/ccf_pkg.sv]
// ----------------------------------------------------------------------------
// ccf_pkg
// Types and width constants for the circumcenter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ccf_pkg;

  // Coordinate width; all internal widths follow from it.
  localparam int CB   = 24;
  localparam int DW   = CB + 1;            // point differences
  localparam int PPW  = 2 * DW;            // difference products
  localparam int DDW  = 2 * DW + 1;        // determinant
  localparam int LW   = 2 * DW;            // squared lengths
  localparam int HB   = DW;                // low split of a squared length
  localparam int HW   = LW - HB;           // high split of a squared length
  localparam int PLW  = DW + HB + 1;       // partial product, low half
  localparam int PHW  = DW + HW + 1;       // partial product, high half
  localparam int NW   = DW + LW + 1;       // numerators
  localparam int NUW  = NW + 1;            // dividend magnitude
  localparam int MW   = DDW + 1;           // divisor 2|D|
  localparam int QB   = CB + 1;            // quotient bits kept
  localparam int CW   = (NUW > MW + QB) ? NUW : MW + QB;
  localparam int SW   = CB + 3;            // sum of base and offset
  localparam int DIV_LAT = QB + 1;

  localparam logic signed [SW-1:0] SAT_MAX = $signed({{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}});
  localparam logic signed [SW-1:0] SAT_MIN = $signed({{(SW-CB+1){1'b1}}, {(CB-1){1'b0}}});

  typedef struct packed {
    logic signed [CB-1:0] p1_x;
    logic signed [CB-1:0] p1_y;
    logic signed [CB-1:0] p2_x;
    logic signed [CB-1:0] p2_y;
    logic signed [CB-1:0] p3_x;
    logic signed [CB-1:0] p3_y;
  } ccf_in_t;

  typedef struct packed {
    logic signed [CB-1:0] center_x;
    logic signed [CB-1:0] center_y;
    logic                 colinear;
    logic                 overflow;
  } ccf_out_t;

  // Sideband that rides alongside the dividers.
  typedef struct packed {
    logic                 neg_x;
    logic                 neg_y;
    logic                 colin;
    logic signed [CB-1:0] base_x;
    logic signed [CB-1:0] base_y;
  } ccf_side_t;

  // Front end result: dividends, divisor and sideband.
  typedef struct packed {
    logic [NUW-1:0] n_x;
    logic [NUW-1:0] n_y;
    logic [MW-1:0]  m;
    ccf_side_t      side;
  } ccf_num_t;

  typedef struct packed {
    logic                 ovf;
    logic signed [CB-1:0] val;
  } ccf_axis_t;

  // Adds the signed offset to the base and saturates.
  function automatic ccf_axis_t ccf_sat(input logic signed [CB-1:0] base,
                                        input logic [QB-1:0] q,
                                        input logic neg,
                                        input logic dovf);
    logic signed [SW-1:0] qs;
    logic signed [SW-1:0] s;
    ccf_axis_t            r;
    qs = $signed(SW'(q));
    s  = SW'(base) + (neg ? -qs : qs);
    r.ovf = 1'b0;
    r.val = CB'(s);
    if (dovf) begin
      r.ovf = 1'b1;
      r.val = neg ? CB'(SAT_MIN) : CB'(SAT_MAX);
    end else if (s > SAT_MAX) begin
      r.ovf = 1'b1;
      r.val = CB'(SAT_MAX);
    end else if (s < SAT_MIN) begin
      r.ovf = 1'b1;
      r.val = CB'(SAT_MIN);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/ccf_numer.sv]
// ----------------------------------------------------------------------------
// ccf_numer
// Eight stage front end: differences, determinant, squared lengths and the
// two center numerators, delivered as dividend and divisor magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module ccf_numer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  ccf_pkg::ccf_in_t data_i,
  output logic             valid_o,
  output ccf_pkg::ccf_num_t num_o
);
  import ccf_pkg::*;

  localparam int NSTG = 8;

  logic [NSTG-1:0] v_q;

  logic signed [DW-1:0]  bx1_q, by1_q, cx1_q, cy1_q;
  logic signed [CB-1:0]  x1_q [NSTG-1];
  logic signed [CB-1:0]  y1_q [NSTG-1];

  logic signed [PPW-1:0] pbc2_q, pbd2_q, sbx2_q, sby2_q, scx2_q, scy2_q;
  logic signed [DW-1:0]  bx2_q, by2_q, cx2_q, cy2_q;

  logic signed [DDW-1:0] d3_q;
  logic [LW-1:0]         lb3_q, lc3_q;
  logic signed [DW-1:0]  bx3_q, by3_q, cx3_q, cy3_q;

  logic signed [PLW-1:0] l_cy4_q, l_by4_q, l_bx4_q, l_cx4_q;
  logic signed [PHW-1:0] h_cy4_q, h_by4_q, h_bx4_q, h_cx4_q;
  logic signed [DDW-1:0] d4_q;

  logic signed [NW-1:0]  t_cy5_q, t_by5_q, t_bx5_q, t_cx5_q;
  logic signed [DDW-1:0] d5_q;

  logic signed [NW-1:0]  nx6_q, ny6_q;
  logic signed [DDW-1:0] d6_q;

  logic [NW-1:0]         anx7_q, any7_q;
  logic [DDW-1:0]        ad7_q;
  logic                  negx7_q, negy7_q, zero7_q;

  ccf_num_t              num_q;

  // Valid bits move with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NSTG-2:0], valid_i};
    end
  end

  // Datapath stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage 1: offsets from the first point.
      bx1_q <= DW'(data_i.p2_x) - DW'(data_i.p1_x);
      by1_q <= DW'(data_i.p2_y) - DW'(data_i.p1_y);
      cx1_q <= DW'(data_i.p3_x) - DW'(data_i.p1_x);
      cy1_q <= DW'(data_i.p3_y) - DW'(data_i.p1_y);
      x1_q[0] <= data_i.p1_x;
      y1_q[0] <= data_i.p1_y;
      for (int k = 1; k < NSTG - 1; k++) begin
        x1_q[k] <= x1_q[k-1];
        y1_q[k] <= y1_q[k-1];
      end

      // Stage 2: products of differences.
      pbc2_q <= bx1_q * cy1_q;
      pbd2_q <= by1_q * cx1_q;
      sbx2_q <= bx1_q * bx1_q;
      sby2_q <= by1_q * by1_q;
      scx2_q <= cx1_q * cx1_q;
      scy2_q <= cy1_q * cy1_q;
      bx2_q  <= bx1_q;
      by2_q  <= by1_q;
      cx2_q  <= cx1_q;
      cy2_q  <= cy1_q;

      // Stage 3: determinant and squared lengths.
      d3_q  <= DDW'(pbc2_q) - DDW'(pbd2_q);
      lb3_q <= LW'($unsigned(sbx2_q)) + LW'($unsigned(sby2_q));
      lc3_q <= LW'($unsigned(scx2_q)) + LW'($unsigned(scy2_q));
      bx3_q <= bx2_q;
      by3_q <= by2_q;
      cx3_q <= cx2_q;
      cy3_q <= cy2_q;

      // Stage 4: split products against the squared lengths.
      l_cy4_q <= cy3_q * $signed({1'b0, lb3_q[HB-1:0]});
      h_cy4_q <= cy3_q * $signed({1'b0, lb3_q[LW-1:HB]});
      l_by4_q <= by3_q * $signed({1'b0, lc3_q[HB-1:0]});
      h_by4_q <= by3_q * $signed({1'b0, lc3_q[LW-1:HB]});
      l_bx4_q <= bx3_q * $signed({1'b0, lc3_q[HB-1:0]});
      h_bx4_q <= bx3_q * $signed({1'b0, lc3_q[LW-1:HB]});
      l_cx4_q <= cx3_q * $signed({1'b0, lb3_q[HB-1:0]});
      h_cx4_q <= cx3_q * $signed({1'b0, lb3_q[LW-1:HB]});
      d4_q    <= d3_q;

      // Stage 5: merge the halves.
      t_cy5_q <= (NW'(h_cy4_q) <<< HB) + NW'(l_cy4_q);
      t_by5_q <= (NW'(h_by4_q) <<< HB) + NW'(l_by4_q);
      t_bx5_q <= (NW'(h_bx4_q) <<< HB) + NW'(l_bx4_q);
      t_cx5_q <= (NW'(h_cx4_q) <<< HB) + NW'(l_cx4_q);
      d5_q    <= d4_q;

      // Stage 6: numerators.
      nx6_q <= t_cy5_q - t_by5_q;
      ny6_q <= t_bx5_q - t_cx5_q;
      d6_q  <= d5_q;

      // Stage 7: magnitudes and quotient signs.
      anx7_q  <= nx6_q[NW-1] ? NW'(-nx6_q) : NW'(nx6_q);
      any7_q  <= ny6_q[NW-1] ? NW'(-ny6_q) : NW'(ny6_q);
      ad7_q   <= d6_q[DDW-1] ? DDW'(-d6_q) : DDW'(d6_q);
      negx7_q <= nx6_q[NW-1] ^ d6_q[DDW-1];
      negy7_q <= ny6_q[NW-1] ^ d6_q[DDW-1];
      zero7_q <= (d6_q == '0);

      // Stage 8: rounding bias and doubled divisor.
      num_q.n_x         <= NUW'(anx7_q) + NUW'(ad7_q);
      num_q.n_y         <= NUW'(any7_q) + NUW'(ad7_q);
      num_q.m           <= {ad7_q, 1'b0};
      num_q.side.neg_x  <= negx7_q;
      num_q.side.neg_y  <= negy7_q;
      num_q.side.colin  <= zero7_q;
      num_q.side.base_x <= x1_q[NSTG-2];
      num_q.side.base_y <= y1_q[NSTG-2];
    end
  end

  assign valid_o = v_q[NSTG-1];
  assign num_o   = num_q;

endmodule

`default_nettype wire

[sv/ccf_div.sv]
// ----------------------------------------------------------------------------
// ccf_div
// Pipelined restoring divider: a range check stage, then one quotient bit
// per stage, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module ccf_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [ccf_pkg::NUW-1:0]   n_i,
  input  logic [ccf_pkg::MW-1:0]    m_i,
  output logic [ccf_pkg::QB-1:0]    q_o,
  output logic                      ovf_o
);
  import ccf_pkg::*;

  logic [CW-1:0] r_q [QB+1];
  logic [MW-1:0] m_q [QB+1];
  logic [QB-1:0] q_q [QB+1];
  logic          o_q [QB+1];
  logic [CW:0]   trial [QB];

  // Trial subtraction of the divisor at each bit weight.
  always_comb begin
    for (int k = 1; k <= QB; k++) begin
      trial[k-1] = {1'b0, r_q[k-1]} - ({1'b0, CW'(m_q[k-1])} << (QB - k));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Range check: the quotient must fit in the kept bits.
      r_q[0] <= CW'(n_i);
      m_q[0] <= m_i;
      q_q[0] <= '0;
      o_q[0] <= (CW'(n_i) >= (CW'(m_i) << QB));
      // One quotient bit per stage.
      for (int k = 1; k <= QB; k++) begin
        r_q[k] <= trial[k-1][CW] ? r_q[k-1] : trial[k-1][CW-1:0];
        q_q[k] <= q_q[k-1] | (trial[k-1][CW] ? QB'(0) : (QB'(1) << (QB - k)));
        m_q[k] <= m_q[k-1];
        o_q[k] <= o_q[k-1];
      end
    end
  end

  assign q_o   = q_q[QB];
  assign ovf_o = o_q[QB];

endmodule

`default_nettype wire

[sv/circle_center_from_three_points.sv]
// ----------------------------------------------------------------------------
// circle_center_from_three_points
// Center of the circle through three points, Q15.8, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | valid        | stall        | payload
//  in      | in_valid_i   | in_stall_o   | in_data_i  (three points)
//  out     | out_valid_o  | out_stall_i  | out_data_o (center and flags)
//
// One beat is accepted per cycle while the output is not stalled. The pipeline is 8 front end stages,
// 26 divider stages (a range check, then one quotient bit each) and the output register.
// The whole pipeline advances together; a stalled output beat freezes it.
// Reset clears only the valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_center_from_three_points (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ccf_pkg::ccf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ccf_pkg::ccf_out_t out_data_o
);
  import ccf_pkg::*;

  `include "assert_macros.svh"

  localparam logic signed [CB-1:0] CMAX = CB'(SAT_MAX);
  localparam logic signed [CB-1:0] CMIN = CB'(SAT_MIN);

  logic      en;
  logic      fe_valid;
  ccf_num_t  fe_num;
  logic [QB-1:0] qx, qy;
  logic      ovx, ovy;
  logic      vld_q [DIV_LAT];
  ccf_side_t side_q [DIV_LAT];
  ccf_side_t tail;
  ccf_axis_t ax, ay;
  logic      out_vld_q;
  ccf_out_t  out_q;

  // Pipeline moves unless a result beat is held.
  assign en         = !out_vld_q || !out_stall_i;
  assign in_stall_o = !en;

  ccf_numer u_numer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (fe_valid),
    .num_o   (fe_num)
  );

  ccf_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (fe_num.n_x),
    .m_i   (fe_num.m),
    .q_o   (qx),
    .ovf_o (ovx)
  );

  ccf_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (fe_num.n_y),
    .m_i   (fe_num.m),
    .q_o   (qy),
    .ovf_o (ovy)
  );

  // Valid bits alongside the dividers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_LAT; k++) vld_q[k] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= fe_valid;
      for (int k = 1; k < DIV_LAT; k++) vld_q[k] <= vld_q[k-1];
      out_vld_q <= vld_q[DIV_LAT-1];
    end
  end

  // Sideband alongside the dividers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= fe_num.side;
      for (int k = 1; k < DIV_LAT; k++) side_q[k] <= side_q[k-1];
    end
  end

  assign tail = side_q[DIV_LAT-1];

  // Final add and saturation.
  always_comb begin
    ax = ccf_sat(tail.base_x, qx, tail.neg_x, ovx);
    ay = ccf_sat(tail.base_y, qy, tail.neg_y, ovy);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (tail.colin) begin
        out_q.center_x <= '0;
        out_q.center_y <= '0;
        out_q.colinear <= 1'b1;
        out_q.overflow <= 1'b0;
      end else begin
        out_q.center_x <= ax.val;
        out_q.center_y <= ay.val;
        out_q.colinear <= 1'b0;
        out_q.overflow <= ax.ovf | ay.ovf;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A colinear beat carries a zero center and no overflow.
  `CCF_ASSERT(a_colin_zero, clk_i, rst_ni, (out_valid_o && out_data_o.colinear) |-> (out_data_o.center_x == '0 && out_data_o.center_y == '0 && !out_data_o.overflow), "colinear beat with nonzero center")
  // An overflow beat has at least one coordinate at a rail.
  `CCF_ASSERT(a_ovf_rail, clk_i, rst_ni, (out_valid_o && out_data_o.overflow) |-> (out_data_o.center_x == CMAX || out_data_o.center_x == CMIN || out_data_o.center_y == CMAX || out_data_o.center_y == CMIN), "overflow without saturation")
  // A bubble at the divider tail empties the output register.
  `CCF_ASSERT(a_bubble, clk_i, rst_ni, (en && !vld_q[DIV_LAT-1]) |=> !out_valid_o, "output valid without a beat behind it")

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Streams point triples into circle_center_from_three_points, predicts each
// circumcenter with exact wide arithmetic, and compares every output beat in
// order under random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import ccf_pkg::*;

  localparam int  LIMIT_CYCLES = 2_000_000;
  localparam int  DRAIN_CYCLES = 60;
  localparam int  HOLD_CYCLES  = 200;
  localparam longint MAX_C = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint MIN_C = -(64'sd1 <<< (CB - 1));

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  ccf_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  ccf_out_t out_data_o;

  int  send_pct;
  int  recv_pct;
  bit  hold_req;
  int  cycle_cnt;

  circle_center_from_three_points i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Holds the centers still owed by the block and checks them in order.
  class center_board;
    ccf_out_t pending[$];
    int       errors;

    // One axis: base + round(num / 2det), ties away from zero, saturated.
    function automatic logic [CB-1:0] offset_axis(logic signed [127:0] num,
                                                  logic signed [127:0] det,
                                                  longint base, ref bit ovf);
      logic [127:0] mag_n;
      logic [127:0] mag_d;
      logic [127:0] quo;
      bit           neg;
      longint       s;
      neg   = (num < 0) != (det < 0);
      mag_n = (num < 0) ? -num : num;
      mag_d = (det < 0) ? -det : det;
      quo   = (mag_n + mag_d) / (mag_d << 1);
      if (quo >= (128'd1 << (CB + 1))) begin
        ovf = 1;
        return neg ? CB'(MIN_C) : CB'(MAX_C);
      end
      s = neg ? base - longint'(quo) : base + longint'(quo);
      if (s > MAX_C) begin
        ovf = 1;
        return CB'(MAX_C);
      end
      if (s < MIN_C) begin
        ovf = 1;
        return CB'(MIN_C);
      end
      return CB'(s);
    endfunction

    function automatic ccf_out_t circumcenter(ccf_in_t p);
      logic signed [127:0] bx, by, cx, cy, det, lb, lc, nx, ny;
      ccf_out_t r;
      bit       ovf;
      bx  = 128'(p.p2_x) - 128'(p.p1_x);
      by  = 128'(p.p2_y) - 128'(p.p1_y);
      cx  = 128'(p.p3_x) - 128'(p.p1_x);
      cy  = 128'(p.p3_y) - 128'(p.p1_y);
      det = bx * cy - by * cx;
      r   = '0;
      if (det == 0) begin
        r.colinear = 1'b1;
        return r;
      end
      ovf = 0;
      lb  = bx * bx + by * by;
      lc  = cx * cx + cy * cy;
      nx  = cy * lb - by * lc;
      ny  = bx * lc - cx * lb;
      r.center_x = offset_axis(nx, det, longint'(p.p1_x), ovf);
      r.center_y = offset_axis(ny, det, longint'(p.p1_y), ovf);
      r.overflow = ovf;
      return r;
    endfunction

    function void note_input(ccf_in_t p);
      pending.push_back(circumcenter(p));
    endfunction

    function void check_center(ccf_out_t got);
      ccf_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output beat %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.center_x !== want.center_x) begin
        $display("%0t: center_x expected %h actual %h", $time, want.center_x, got.center_x);
        errors++;
      end
      if (got.center_y !== want.center_y) begin
        $display("%0t: center_y expected %h actual %h", $time, want.center_y, got.center_y);
        errors++;
      end
      if (got.colinear !== want.colinear) begin
        $display("%0t: colinear expected %b actual %b", $time, want.colinear, got.colinear);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow expected %b actual %b", $time, want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  center_board board = new();

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog.
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt >= LIMIT_CYCLES) begin
        $display("circle_center_from_three_points: mismatch");
        $finish;
      end
    end
  end

  // Monitor: note accepted input beats and check accepted output beats.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) board.check_center(out_data_o);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int held;
    out_stall_i = 1'b1;
    held = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        held++;
        if (held >= HOLD_CYCLES) begin
          hold_req = 0;
          held = 0;
        end
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  // Offers one beat after a random gap; returns on the falling edge after
  // acceptance with valid still high.
  task automatic send_points(ccf_in_t p);
    while ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic [CB-1:0] rnd_coord();
    return CB'($urandom);
  endfunction

  function automatic logic [CB-1:0] near(logic [CB-1:0] c, int span);
    return c + CB'($urandom_range(2 * span) - span);
  endfunction

  // Random triple: wide, clustered, colinear or nearly colinear.
  function automatic ccf_in_t random_points();
    ccf_in_t p;
    int      kind;
    int      k;
    logic [CB-1:0] dx, dy;
    kind = $urandom_range(9);
    p.p1_x = rnd_coord();
    p.p1_y = rnd_coord();
    case (kind) inside
      [0:2]: begin
        p.p2_x = rnd_coord(); p.p2_y = rnd_coord();
        p.p3_x = rnd_coord(); p.p3_y = rnd_coord();
      end
      [3:5]: begin
        p.p1_x = near('0, 1 << $urandom_range(20));
        p.p1_y = near('0, 1 << $urandom_range(20));
        k = 1 << $urandom_range(16);
        p.p2_x = near(p.p1_x, k); p.p2_y = near(p.p1_y, k);
        p.p3_x = near(p.p1_x, k); p.p3_y = near(p.p1_y, k);
      end
      [6:7]: begin
        dx = near('0, 1 << $urandom_range(10));
        dy = near('0, 1 << $urandom_range(10));
        k  = $urandom_range(40) - 20;
        p.p2_x = p.p1_x + dx;             p.p2_y = p.p1_y + dy;
        p.p3_x = p.p1_x + CB'(dx * k);    p.p3_y = p.p1_y + CB'(dy * k);
      end
      default: begin
        dx = near('0, 1 << $urandom_range(12));
        dy = near('0, 1 << $urandom_range(12));
        k  = $urandom_range(40) - 20;
        p.p2_x = p.p1_x + dx;      p.p2_y = p.p1_y + dy;
        p.p3_x = near(p.p1_x + CB'(dx * k), 1);
        p.p3_y = near(p.p1_y + CB'(dy * k), 1);
      end
    endcase
    return p;
  endfunction

  function automatic ccf_in_t pts(longint ax, longint ay, longint bx, longint by,
                                  longint cx, longint cy);
    ccf_in_t p;
    p.p1_x = CB'(ax); p.p1_y = CB'(ay);
    p.p2_x = CB'(bx); p.p2_y = CB'(by);
    p.p3_x = CB'(cx); p.p3_y = CB'(cy);
    return p;
  endfunction

  // Main sequence.
  initial begin
    ccf_in_t directed[$];
    in_valid_i = 1'b0;
    in_data_i  = '0;
    send_pct   = 0;
    recv_pct   = 0;
    hold_req   = 0;
    rst_ni     = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Coincident, colinear, unit and right triangles; three rounding ties.
    directed.push_back(pts(0, 0, 0, 0, 0, 0));
    directed.push_back(pts(MAX_C, MIN_C, MAX_C, MIN_C, MAX_C, MIN_C));
    directed.push_back(pts(0, 0, 256, 256, 512, 512));
    directed.push_back(pts(0, 0, 1, 0, 0, 1));
    directed.push_back(pts(0, 0, -1, 0, 0, -1));
    directed.push_back(pts(0, 0, 3, 0, 0, 5));
    directed.push_back(pts(256, 0, 0, 256, -256, 0));
    // Extreme corners.
    directed.push_back(pts(MIN_C, MIN_C, MAX_C, MIN_C, MIN_C, MAX_C));
    directed.push_back(pts(MAX_C, MAX_C, MIN_C, MAX_C, MAX_C, MIN_C));
    directed.push_back(pts(MIN_C, MAX_C, MAX_C, MAX_C, MAX_C, MIN_C));
    directed.push_back(pts(MAX_C, 0, MIN_C, 0, 0, MAX_C));
    // Nearly colinear, saturating either way; then rail and small cases.
    directed.push_back(pts(0, 0, MAX_C, 0, MIN_C, 1));
    directed.push_back(pts(0, 0, MAX_C, 0, MIN_C, -1));
    directed.push_back(pts(0, 0, 0, MAX_C, 1, MIN_C));
    directed.push_back(pts(0, 0, 0, MAX_C, -1, MIN_C));
    directed.push_back(pts(MAX_C, MAX_C, MAX_C - 2, MAX_C, MAX_C, MAX_C - 2));
    directed.push_back(pts(MIN_C, MIN_C, MIN_C + 2, MIN_C, MIN_C, MIN_C + 2));
    directed.push_back(pts(0, 0, 1, 1, 2, 3));
    directed.push_back(pts(-1, -1, -1, -1, 5, 7));
    foreach (directed[i]) send_points(directed[i]);

    // Three idling phases; the long hold-off falls in the last one.
    for (int ph = 0; ph < 3; ph++) begin
      send_pct = (ph == 0) ? 31 : (ph == 1) ? 84 : 0;
      recv_pct = (ph == 0) ? 84 : (ph == 1) ? 31 : 0;
      for (int n = 0; n < 660; n++) begin
        if (ph == 2 && n == 100) hold_req = 1;
        send_points(random_points());
      end
    end
    in_valid_i <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("circle_center_from_three_points: match");
    end else begin
      $display("circle_center_from_three_points: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/ccf_pkg.sv
sv/ccf_numer.sv
sv/ccf_div.sv
sv/circle_center_from_three_points.sv
tb/sv/tb.sv
